// ===== sv/rcv_pkg.sv =====
// Shared types, codes and a helper function for the radix converter.
`default_nettype none
package rcv_pkg;

	// Result error codes.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
	localparam logic [1:0] ERR_RANGE    = 2'd2;

	// Configuration register indexes.
	localparam logic [7:0] CFG_OLD_BASE = 8'd0;
	localparam logic [7:0] CFG_NEW_BASE = 8'd1;

	// ASCII constants.
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_Z     = 8'h5A;

	// Radix limits for the output base.
	localparam logic [5:0] BASE_MIN = 6'd2;
	localparam logic [5:0] BASE_MAX = 6'd36;

	// Decoded form of one incoming character.
	typedef struct packed {
		logic       is_space;
		logic       bad;
		logic [5:0] digit;
	} dec_t;

	// One step of the restoring divider.
	typedef struct packed {
		logic [5:0] rem;
		logic       q_bit;
	} div_step_t;

	// Digit value 0..35 to its ASCII character.
	function automatic logic [7:0] digit_to_ascii(input logic [5:0] d);
		logic [7:0] d8;
		d8 = {2'b00, d};
		if (d <= 6'd9) begin
			return CHAR_ZERO + d8;
		end else begin
			return CHAR_A + (d8 - 8'd10);
		end
	endfunction

endpackage
`default_nettype wire

// ===== sv/rcv_decode.sv =====
// Character decoder: classifies an ASCII byte and yields its digit value.
`default_nettype none
module rcv_decode (
	input  wire logic [7:0]    char_in,
	output rcv_pkg::dec_t      dec
);
	import rcv_pkg::*;

	always_comb begin
		dec.is_space = (char_in == CHAR_SPACE);
		dec.bad      = 1'b0;
		dec.digit    = '0;
		if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
			dec.digit = 6'(char_in - CHAR_ZERO);
		end else if (char_in >= CHAR_A && char_in <= CHAR_Z) begin
			dec.digit = 6'(char_in - CHAR_A + 8'd10);
		end else if (!dec.is_space) begin
			dec.bad = 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/rcv_divstep.sv =====
// Shift-subtract unit: one bit of a restoring division by a small base.
`default_nettype none
module rcv_divstep (
	input  wire logic [5:0]     rem_in,
	input  wire logic           bit_in,
	input  wire logic [5:0]     base,
	output rcv_pkg::div_step_t  step
);
	import rcv_pkg::*;

	logic [6:0] trial;
	logic [6:0] diff;

	assign trial = {rem_in, bit_in};
	assign diff  = trial - {1'b0, base};

	always_comb begin
		step.q_bit = (trial >= {1'b0, base});
		step.rem   = step.q_bit ? diff[5:0] : trial[5:0];
	end

endmodule
`default_nettype wire

// ===== sv/radix_converter_base2_36.sv =====
// Top level of the radix converter: accumulator, divider sequencer and result register.
// A character without is_last only folds into the accumulator and gives no result. On a character
// with is_last, an error result or a lone '0' appears in the cycle after the request.
// Otherwise the one-bit-per-cycle divider produces the output digits one after another,
// and busy stays high throughout.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset clears the accumulator, pending error and sequencer; both bases return to 10.
`default_nettype none
module radix_converter_base2_36 #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Request channel.
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] char_in,
	input  wire logic       is_last,
	// Configuration write channel.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	// Result strobe and payload.
	output logic            result_valid,
	output logic [7:0]      digit_char,
	output logic [1:0]      error_code,
	output logic            last_digit
);
	import rcv_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VALUE_BITS - 1);

	// Sequencer states.
	localparam logic S_IDLE = 1'b0;
	localparam logic S_DIV  = 1'b1;

	logic                  state_q;
	logic [5:0]            old_base_q;
	logic [5:0]            new_base_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [1:0]            pend_q;

	// Divider registers: quotient shifts in from the bottom as the dividend leaves the top.
	logic [VALUE_BITS-1:0] quo_q;
	logic [5:0]            rem_q;
	logic [5:0]            base_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  res_valid_q;
	logic [7:0]            digit_q;
	logic [1:0]            err_q;
	logic                  last_q;

	dec_t                  dec;
	div_step_t             step;
	logic                  accept;
	logic [VALUE_BITS-1:0] acc_next;
	logic [VALUE_BITS+5:0] product;
	logic [1:0]            pend_next;
	logic [5:0]            base_clamped;
	logic [VALUE_BITS-1:0] quo_next;

	rcv_decode u_decode (
		.char_in (char_in),
		.dec     (dec)
	);

	rcv_divstep u_divstep (
		.rem_in (rem_q),
		.bit_in (quo_q[VALUE_BITS-1]),
		.base   (base_q),
		.step   (step)
	);

	assign busy      = (state_q == S_DIV);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Fold the incoming digit into the accumulator; the product wraps at VALUE_BITS.
	assign product = acc_q * {{VALUE_BITS{1'b0}}, old_base_q};

	always_comb begin
		acc_next  = acc_q;
		pend_next = pend_q;
		if (dec.bad) begin
			// An invalid character overrides any earlier range error.
			pend_next = ERR_BAD_CHAR;
		end else if (!dec.is_space) begin
			if (dec.digit >= old_base_q && pend_q == ERR_NONE) begin
				pend_next = ERR_RANGE;
			end
			acc_next = product[VALUE_BITS-1:0] + VALUE_BITS'(dec.digit);
		end
	end

	// Output bases outside 2..36 are clamped when a conversion starts.
	always_comb begin
		if (new_base_q < BASE_MIN) begin
			base_clamped = BASE_MIN;
		end else if (new_base_q > BASE_MAX) begin
			base_clamped = BASE_MAX;
		end else begin
			base_clamped = new_base_q;
		end
	end

	assign quo_next = {quo_q[VALUE_BITS-2:0], step.q_bit};

	// Configuration registers; writes to indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_base_q <= 6'd10;
			new_base_q <= 6'd10;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_OLD_BASE) begin
				old_base_q <= cfg_data;
			end else if (cfg_index == CFG_NEW_BASE) begin
				new_base_q <= cfg_data;
			end
		end
	end

	// Control: accumulator, pending error, sequencer and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			pend_q      <= ERR_NONE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_last) begin
							// The run ends here; clear for the next number.
							acc_q  <= '0;
							pend_q <= ERR_NONE;
							if (pend_next != ERR_NONE || acc_next == '0) begin
								res_valid_q <= 1'b1;
							end else begin
								state_q <= S_DIV;
								cnt_q   <= CNT_MAX;
							end
						end else begin
							acc_q  <= acc_next;
							pend_q <= pend_next;
						end
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						// One digit is finished; stop once the quotient reaches zero.
						res_valid_q <= 1'b1;
						cnt_q       <= CNT_MAX;
						if (quo_next == '0) begin
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: divider operands and result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (accept && is_last) begin
				quo_q  <= acc_next;
				rem_q  <= '0;
				base_q <= base_clamped;
				if (pend_next != ERR_NONE) begin
					digit_q <= '0;
					err_q   <= pend_next;
					last_q  <= 1'b1;
				end else begin
					digit_q <= CHAR_ZERO;
					err_q   <= ERR_NONE;
					last_q  <= 1'b1;
				end
			end
		end else begin
			quo_q <= quo_next;
			if (cnt_q == '0) begin
				rem_q   <= '0;
				digit_q <= digit_to_ascii(step.rem);
				err_q   <= ERR_NONE;
				last_q  <= (quo_next == '0);
			end else begin
				rem_q <= step.rem;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign digit_char   = digit_q;
	assign error_code   = err_q;
	assign last_digit   = last_q;

	// An error result always ends its run and carries no digit.
	a_err_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_code != ERR_NONE |-> last_digit && digit_char == 8'd0)
		else $error("error result without last_digit or with a digit");

	// A digit that is not the last one means the divider is still running.
	a_more_digits_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_digit |-> busy)
		else $error("intermediate digit while sequencer idle");

	// A character without is_last never produces a result.
	a_no_result_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !is_last |=> !result_valid)
		else $error("result after a character without is_last");

	// While a digit is being divided out, no result is strobed in the next cycle.
	a_quiet_during_divide: assert property (@(posedge clk) disable iff (!arst_n)
		busy && cnt_q != '0 |=> !result_valid)
		else $error("result strobed in the middle of a division");

endmodule
`default_nettype wire
